>>> hw/rtl/rbe_pkg.sv
// Shared types and constants for the RGB LED brightness bit encoder.
// No dependencies; every other file of the block refers to it by scoped name.
package rbe_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned ProdW      = 2 * ChanW;
  localparam int unsigned WordW      = 3 * ChanW;
  localparam int unsigned CntW       = $clog2(WordW);
  localparam int unsigned TickW      = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CntW-1:0]   LastCnt     = CntW'(WordW - 1);
  localparam logic [TickW-1:0]  TicksLong   = 4'd8;
  localparam logic [TickW-1:0]  TicksShort  = 4'd4;
  localparam logic [ChanW-1:0]  BrightReset = 8'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBrightness = 2'd0,
    CfgSwapRedGrn = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic             swap_red_green;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic msb;
  } ser_stat_t;

endpackage

>>> hw/rtl/rbe_if.sv
// Valid/ready channel interfaces for colors in and line symbols out.
// Depends on rbe_pkg for the field widths.
interface rbe_in_if;
  logic                      valid;
  logic                      ready;
  logic [rbe_pkg::ChanW-1:0] red;
  logic [rbe_pkg::ChanW-1:0] green;
  logic [rbe_pkg::ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rbe_out_if;
  logic                      valid;
  logic                      ready;
  logic [rbe_pkg::TickW-1:0] high_ticks;
  logic [rbe_pkg::TickW-1:0] low_ticks;
  logic                      last_symbol;

  modport source (output valid, output high_ticks, output low_ticks, output last_symbol,
                  input ready);
  modport sink   (input valid, input high_ticks, input low_ticks, input last_symbol,
                  output ready);
endinterface

>>> hw/rtl/rgb_led_brightness_bit_encoder.sv
// RGB LED brightness bit encoder top level: config registers, lanes, merge, serializer.
// Depends on rbe_pkg, rbe_if, rbe_lane, rbe_merge and rbe_ser.
//
// Each accepted color produces 24 line symbols, one per output transfer, in GRB order
// (RGB when swapped), most significant bit first; the 24th carries last_symbol. Three
// lanes scale the channels by brightness/255 in parallel, in the cycle after the color
// is accepted; the serializer then loads the word into its register and emits one
// symbol per cycle while the output is ready. It reloads on the same edge that takes the
// last symbol, so with the output always ready the next color streams out with no gap.
// Configuration is sampled as a color enters the lanes (brightness) and as the
// serializer loads (red/green swap), so write it only while the block is idle.
module rgb_led_brightness_bit_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbe_pkg::CfgDataW-1:0] cfg_wdata_i,
  rbe_in_if.sink                       in_i,
  rbe_out_if.source                    out_o
);

  rbe_pkg::cfg_t             cfg_q, cfg_d;
  logic                      s1_vld_q, s1_vld_d;
  logic                      in_fire, out_fire, ser_ready, ser_load;
  logic [rbe_pkg::ChanW-1:0] red_s, green_s, blue_s;
  logic [rbe_pkg::WordW-1:0] word;
  rbe_pkg::ser_stat_t        stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rbe_pkg::cfg_idx_e'(cfg_idx_i))
        rbe_pkg::CfgBrightness: cfg_d.brightness     = cfg_wdata_i[rbe_pkg::ChanW-1:0];
        rbe_pkg::CfgSwapRedGrn: cfg_d.swap_red_green = cfg_wdata_i[0];
        default:                cfg_d                = cfg_q;
      endcase
    end
  end

  assign out_fire  = out_o.valid && out_o.ready;
  assign ser_ready = !stat.busy || (out_fire && stat.last);
  assign ser_load  = s1_vld_q && ser_ready;
  assign in_i.ready = !s1_vld_q || ser_ready;
  assign in_fire   = in_i.valid && in_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (ser_load) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness     <= rbe_pkg::BrightReset;
      cfg_q.swap_red_green <= 1'b0;
      s1_vld_q             <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  rbe_lane u_lane_red (
    .clk_i    (clk_i),
    .en_i     (in_fire),
    .chan_i   (in_i.red),
    .bright_i (cfg_q.brightness),
    .scaled_o (red_s)
  );

  rbe_lane u_lane_green (
    .clk_i    (clk_i),
    .en_i     (in_fire),
    .chan_i   (in_i.green),
    .bright_i (cfg_q.brightness),
    .scaled_o (green_s)
  );

  rbe_lane u_lane_blue (
    .clk_i    (clk_i),
    .en_i     (in_fire),
    .chan_i   (in_i.blue),
    .bright_i (cfg_q.brightness),
    .scaled_o (blue_s)
  );

  rbe_merge u_merge (
    .cfg_i   (cfg_q),
    .red_i   (red_s),
    .green_i (green_s),
    .blue_i  (blue_s),
    .word_o  (word)
  );

  rbe_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ser_load),
    .take_i (out_fire),
    .word_i (word),
    .stat_o (stat)
  );

  assign out_o.valid       = stat.busy;
  assign out_o.high_ticks  = stat.msb ? rbe_pkg::TicksLong : rbe_pkg::TicksShort;
  assign out_o.low_ticks   = stat.msb ? rbe_pkg::TicksShort : rbe_pkg::TicksLong;
  assign out_o.last_symbol = stat.last;

  // A color that has entered the lanes is never dropped.
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !ser_ready |=> s1_vld_q)
    else $error("lane stage lost a color");

  // The serializer never goes idle in the middle of a color.
  a_no_early_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !stat.last |=> stat.busy)
    else $error("serializer stopped before the last symbol");

  // A transfer at the input always lands in the lane stage.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_vld_q)
    else $error("accepted color missing from lane stage");

  // A loaded word starts at its first symbol.
  a_load_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |=> stat.busy && !stat.last)
    else $error("serializer load did not restart the symbol count");

endmodule

>>> hw/rtl/rbe_lane.sv
// One scaling lane: registers channel*brightness, then divides by 255.
// Depends on rbe_pkg for widths.
module rbe_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rbe_pkg::ChanW-1:0] chan_i,
  input  logic [rbe_pkg::ChanW-1:0] bright_i,
  output logic [rbe_pkg::ChanW-1:0] scaled_o
);

  logic [rbe_pkg::ProdW-1:0] prod_q, prod_d;
  logic [rbe_pkg::ProdW:0]   sum;

  assign prod_d = rbe_pkg::ProdW'(chan_i) * rbe_pkg::ProdW'(bright_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Exact x/255 for any product of two 8-bit values: (x + (x >> 8) + 1) >> 8.
  assign sum = {1'b0, prod_q}
             + {{(rbe_pkg::ChanW + 1){1'b0}}, prod_q[rbe_pkg::ProdW-1:rbe_pkg::ChanW]}
             + {{rbe_pkg::ProdW{1'b0}}, 1'b1};
  assign scaled_o = sum[rbe_pkg::ProdW-1:rbe_pkg::ChanW];

endmodule

>>> hw/rtl/rbe_merge.sv
// Merges the three lane results into one GRB word, with optional red/green swap.
// Depends on rbe_pkg for widths and the configuration struct.
module rbe_merge (
  input  rbe_pkg::cfg_t             cfg_i,
  input  logic [rbe_pkg::ChanW-1:0] red_i,
  input  logic [rbe_pkg::ChanW-1:0] green_i,
  input  logic [rbe_pkg::ChanW-1:0] blue_i,
  output logic [rbe_pkg::WordW-1:0] word_o
);

  always_comb begin
    if (cfg_i.swap_red_green) begin
      word_o = {red_i, green_i, blue_i};
    end else begin
      word_o = {green_i, red_i, blue_i};
    end
  end

endmodule

>>> hw/rtl/rbe_ser.sv
// Serializer: shifts a GRB word out one bit per transfer, most significant first.
// Depends on rbe_pkg for widths and the status struct.
module rbe_ser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      take_i,
  input  logic [rbe_pkg::WordW-1:0] word_i,
  output rbe_pkg::ser_stat_t        stat_o
);

  logic [rbe_pkg::WordW-1:0] word_q, word_d;
  logic [rbe_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      last;

  assign last = (cnt_q == rbe_pkg::LastCnt);

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i) begin
      word_d = word_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (take_i) begin
      word_d = {word_q[rbe_pkg::WordW-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.last = last;
  assign stat_o.msb  = word_q[rbe_pkg::WordW-1];

endmodule

>>> test/rgb_led_brightness_bit_encoder_test.sv
// Self-checking testbench for rgb_led_brightness_bit_encoder: colors are scaled, packed GRB
// and serialized into 24 line symbols, which are checked against a local prediction.
// Depends on rbe_pkg, rbe_if and the block's RTL.
module rgb_led_brightness_bit_encoder_test;

  localparam logic [3:0] LongTicks  = 4'd8;
  localparam logic [3:0] ShortTicks = 4'd4;
  localparam int unsigned SymbolsPerColor = 24;
  localparam int unsigned StallLimit      = 3000;
  localparam int unsigned HoldOffCycles   = 300;
  localparam int unsigned IdlePercent     = 7;

  // Indexes that map to no register.
  localparam logic [rbe_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [rbe_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [3:0] high_ticks;
    logic [3:0] low_ticks;
    logic       last_symbol;
  } symbol_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [rbe_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [rbe_pkg::CfgDataW-1:0] cfg_wdata;

  rbe_in_if  in_if ();
  rbe_out_if out_if ();

  rgb_led_brightness_bit_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  color_t      colors_to_send[$];
  symbol_t     symbols_due[$];
  rbe_pkg::cfg_t shadow_cfg;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          in_taken;
  bit          calm;
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] scale_channel(input logic [7:0] chan,
                                               input logic [7:0] level);
    logic [15:0] prod;
    prod = 16'(chan) * 16'(level);
    return 8'(prod / 16'd255);
  endfunction

  task automatic push_color_symbols(input color_t c);
    logic [7:0]  r, g, b, t;
    logic [23:0] word;
    symbol_t     s;
    r = scale_channel(c.red,   shadow_cfg.brightness);
    g = scale_channel(c.green, shadow_cfg.brightness);
    b = scale_channel(c.blue,  shadow_cfg.brightness);
    if (shadow_cfg.swap_red_green) begin
      t = r;
      r = g;
      g = t;
    end
    word = {g, r, b};
    for (int k = SymbolsPerColor - 1; k >= 0; k--) begin
      s.high_ticks  = word[k] ? LongTicks : ShortTicks;
      s.low_ticks   = word[k] ? ShortTicks : LongTicks;
      s.last_symbol = (k == 0);
      symbols_due.push_back(s);
    end
  endtask

  task automatic write_reg(input logic [rbe_pkg::CfgIdxW-1:0] idx,
                           input logic [rbe_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      rbe_pkg::CfgBrightness: shadow_cfg.brightness     = data;
      rbe_pkg::CfgSwapRedGrn: shadow_cfg.swap_red_green = data[0];
      default: ;
    endcase
  endtask

  task automatic add_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    color_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    colors_to_send.push_back(c);
  endtask

  task automatic add_random_colors(input int unsigned n);
    repeat (n) add_color(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
  endtask

  task automatic add_edge_colors();
    add_color(8'h00, 8'h00, 8'h00);
    add_color(8'hFF, 8'hFF, 8'hFF);
    add_color(8'hFF, 8'h00, 8'h00);
    add_color(8'h00, 8'hFF, 8'h00);
    add_color(8'h00, 8'h00, 8'hFF);
    add_color(8'hAA, 8'h55, 8'hAA);
    add_color(8'h55, 8'hAA, 8'h55);
    add_color(8'h01, 8'h80, 8'hFE);
  endtask

  // Sampled at the rising edge, where the valid line and both queues are settled.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (colors_to_send.size() != 0 || in_if.valid || symbols_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : drive_colors
    color_t next_color;
    if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (rst_ni && colors_to_send.size() != 0 &&
          (calm || $urandom_range(99) >= IdlePercent)) begin
        next_color = colors_to_send.pop_front();
        in_if.valid <= 1'b1;
        in_if.red   <= next_color.red;
        in_if.green <= next_color.green;
        in_if.blue  <= next_color.blue;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // The receiver's long hold-off is counted here, apart from the sender.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HoldOffCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    color_t  got_color;
    symbol_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        got_color.red   = in_if.red;
        got_color.green = in_if.green;
        got_color.blue  = in_if.blue;
        push_color_symbols(got_color);
      end
      if (out_if.valid && out_if.ready) begin
        if (symbols_due.size() == 0) begin
          $error("symbol transfer with no symbol expected");
          mismatches++;
        end else begin
          want = symbols_due.pop_front();
          if (out_if.high_ticks !== want.high_ticks) begin
            $error("high_ticks: expected %0d, actual %0d", want.high_ticks, out_if.high_ticks);
            mismatches++;
          end
          if (out_if.low_ticks !== want.low_ticks) begin
            $error("low_ticks: expected %0d, actual %0d", want.low_ticks, out_if.low_ticks);
            mismatches++;
          end
          if (out_if.last_symbol !== want.last_symbol) begin
            $error("last_symbol: expected %0d, actual %0d", want.last_symbol,
                   out_if.last_symbol);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = rbe_pkg::CfgBrightness;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.red    = '0;
    in_if.green  = '0;
    in_if.blue   = '0;
    out_if.ready = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    in_taken     = 1'b0;
    calm         = 1'b0;
    hold_request = 1'b0;
    shadow_cfg.brightness     = 8'd20;
    shadow_cfg.swap_red_green = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Register values straight out of reset.
    add_edge_colors();
    wait_drained();

    // Full scale, and writes to unused indexes must leave the registers alone.
    write_reg(rbe_pkg::CfgBrightness, 8'hFF);
    write_reg(CfgSpareA, 8'h00);
    write_reg(CfgSpareB, 8'h01);
    calm = 1'b1;
    add_edge_colors();
    add_random_colors(60);
    wait_drained();
    calm = 1'b0;

    // A wide swap value keeps only its low bit; the receiver holds off to back up the input.
    write_reg(rbe_pkg::CfgSwapRedGrn, 8'hFF);
    hold_request = 1'b1;
    add_edge_colors();
    add_random_colors(80);
    wait_drained();

    // Zero brightness: everything encodes as zero bits.
    write_reg(rbe_pkg::CfgBrightness, 8'h00);
    write_reg(rbe_pkg::CfgSwapRedGrn, 8'hFE);
    add_color(8'hFF, 8'hFF, 8'hFF);
    add_random_colors(30);
    wait_drained();

    write_reg(rbe_pkg::CfgBrightness, 8'h01);
    write_reg(rbe_pkg::CfgSwapRedGrn, 8'h01);
    add_color(8'hFF, 8'hFE, 8'hFF);
    add_random_colors(40);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_reg(rbe_pkg::CfgBrightness, 8'($urandom_range(255)));
      write_reg(rbe_pkg::CfgSwapRedGrn, 8'($urandom_range(255)));
      add_random_colors(58);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (symbols_due.size() != 0) begin
      $error("%0d expected symbols never arrived", symbols_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
